// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; each expects clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset
`define PPS_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication
`define PPS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PPS_ASSERT(lbl, expr, msg)
`define PPS_ASSERT_IMPL(lbl, ante, cons, msg)
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/pps_pkg.sv =====
package pps_pkg;

   // Default sizing
   localparam int unsigned MAX_WAYPOINTS_DEF = 1024;
   localparam int unsigned CORDIC_STEPS_DEF  = 16;

   // Field widths
   localparam int unsigned ACTION_W   = 2;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned HEAD_W     = 16;
   localparam int unsigned STEER_W    = 15;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned TARGET_W   = 10;
   localparam int unsigned WP_W       = 2 * POS_W;
   localparam int unsigned DIST_W     = 31;
   localparam int unsigned LIMIT_W    = 14;
   localparam int unsigned DIR_W      = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 31;

   // CORDIC datapath widths
   localparam int unsigned CW     = 50;
   localparam int unsigned ZW     = 36;
   localparam int unsigned STEP_W = 5;

   localparam logic signed [ZW-1:0] HALF_PI  = 36'sd1686629713;
   localparam logic signed [CW-1:0] INV_GAIN = 50'sd652032874;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOK_FWD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_FWD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOK_REV    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_REV  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_DIR   = 3'd6;

   // Actions; the spare codes are taken as a pose step
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;

   // Drive directions; anything above reverse means neither
   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd0;
   localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_STEERED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_WP    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_STORED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_ZERO,
      OP_LOAD,
      OP_QTURN,
      OP_ROT,
      OP_SQX,
      OP_SQY,
      OP_SQL,
      OP_VINIT,
      OP_VEC,
      OP_RINIT,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_FINAL
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic side_ok;
      logic dist_ok;
   } dp_status_type;

   typedef struct packed {
      logic [DIST_W-1:0]  wheel_base;
      logic [DIST_W-1:0]  look_fwd;
      logic [DIST_W-1:0]  anchor_fwd;
      logic [DIST_W-1:0]  look_rev;
      logic [DIST_W-1:0]  anchor_rev;
      logic [LIMIT_W-1:0] steer_limit;
      logic [DIR_W-1:0]   drive_direction;
   } cfg_type;

   // atan(2^-i), 2^30 per radian
   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:    v = 36'sh03243F6A8;
         5'd1:    v = 36'sh01DAC6705;
         5'd2:    v = 36'sh00FADBAFC;
         5'd3:    v = 36'sh007F56EA6;
         5'd4:    v = 36'sh003FEAB76;
         5'd5:    v = 36'sh001FFD55B;
         5'd6:    v = 36'sh000FFFAAA;
         5'd7:    v = 36'sh0007FFF55;
         5'd8:    v = 36'sh0003FFFEA;
         5'd9:    v = 36'sh0001FFFFD;
         5'd10:   v = 36'sh0000FFFFF;
         5'd11:   v = 36'sh00007FFFF;
         5'd12:   v = 36'sh00003FFFF;
         5'd13:   v = 36'sh00001FFFF;
         5'd14:   v = 36'sh00000FFFF;
         5'd15:   v = 36'sh000007FFF;
         5'd16:   v = 36'sh000003FFF;
         5'd17:   v = 36'sh000001FFF;
         5'd18:   v = 36'sh000000FFF;
         5'd19:   v = 36'sh0000007FF;
         5'd20:   v = 36'sh0000003FF;
         5'd21:   v = 36'sh0000001FF;
         5'd22:   v = 36'sh0000000FF;
         5'd23:   v = 36'sh00000007F;
         5'd24:   v = 36'sh00000003F;
         5'd25:   v = 36'sh00000001F;
         5'd26:   v = 36'sh00000000F;
         5'd27:   v = 36'sh000000008;
         5'd28:   v = 36'sh000000004;
         5'd29:   v = 36'sh000000002;
         5'd30:   v = 36'sh000000001;
         default: v = 36'sh000000000;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/pps_ram.sv =====
module pps_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pps_datapath.sv =====
module pps_datapath (
   input  logic                                 clock,
   input  pps_pkg::cfg_type                     cfg,
   input  pps_pkg::dp_cmd_type                  cmd,
   input  logic signed [pps_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [pps_pkg::POS_W-1:0]     req_pos_y,
   input  logic signed [pps_pkg::HEAD_W-1:0]    req_heading,
   input  logic [pps_pkg::WP_W-1:0]             wp_data,
   output pps_pkg::dp_status_type               status,
   output logic signed [pps_pkg::STEER_W-1:0]   steer_angle
);

   localparam int unsigned CW = pps_pkg::CW;
   localparam int unsigned ZW = pps_pkg::ZW;

   // Pose latched at accept
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] hd_ff, hd_in;
   // CORDIC vector and angle
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] cz_ff, cz_in;
   logic                 vzero_ff, vzero_in;
   // Distance test
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic               far_ff, far_in;
   logic [63:0]        acc_ff, acc_in;
   // Shared multiplier output and numerator hold
   logic signed [63:0] prod_ff, prod_in, num_ff, num_in;
   logic signed [14:0] steer_ff, steer_in;

   logic                 back;
   logic [30:0]          look, anc;
   logic signed [CW-1:0] cx_sh, cy_sh;
   logic signed [ZW-1:0] atan_v;
   logic [32:0]          ax, ay;
   logic                 far_now;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   mul_p;
   logic signed [31:0]   c_trunc, s_trunc, c_eff, s_eff;
   logic signed [63:0]   look_sh, den_sum, den_shift, num_shift;
   logic signed [ZW-1:0] hd_ext;
   logic signed [32:0]   dx_new, dy_new;
   logic signed [36:0]   zsum;
   logic signed [19:0]   st20, st_dir, lim20, clip, neg20;

   // Direction dependent settings
   assign back = (cfg.drive_direction == pps_pkg::DIR_REVERSE);
   assign look = back ? cfg.look_rev : cfg.look_fwd;
   assign anc  = back ? cfg.anchor_rev : cfg.anchor_fwd;

   // Micro-rotation terms
   assign cx_sh  = cx_ff >>> cmd.step;
   assign cy_sh  = cy_ff >>> cmd.step;
   assign atan_v = pps_pkg::atan_entry(cmd.step);

   // Magnitudes for the distance test
   assign ax      = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay      = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign far_now = (ax > {2'b00, look}) || (ay > {2'b00, look});

   // cos and sin, flipped for reverse
   assign c_trunc = cx_ff[31:0];
   assign s_trunc = cy_ff[31:0];
   assign c_eff   = back ? -c_trunc : c_trunc;
   assign s_eff   = back ? -s_trunc : s_trunc;

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         pps_pkg::OP_SQX: begin
            mul_a = $signed({2'b00, ax[30:0]});
            mul_b = $signed({2'b00, ax[30:0]});
         end
         pps_pkg::OP_SQY: begin
            mul_a = $signed({2'b00, ay[30:0]});
            mul_b = $signed({2'b00, ay[30:0]});
         end
         pps_pkg::OP_SQL: begin
            mul_a = $signed({2'b00, look});
            mul_b = $signed({2'b00, look});
         end
         pps_pkg::OP_MUL1: begin
            mul_a = $signed({2'b00, cfg.wheel_base});
            mul_b = {s_eff[31], s_eff};
         end
         pps_pkg::OP_MUL2: begin
            mul_a = $signed({2'b00, anc});
            mul_b = {c_eff[31], c_eff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Denominator and scaling for the steering atan2
   assign look_sh   = $signed({4'b0000, look, 29'd0});
   assign den_sum   = look_sh + prod_ff;
   assign den_shift = den_sum >>> 16;
   assign num_shift = num_ff >>> 16;

   // Waypoint offset and rotation angle
   assign hd_ext = {{(ZW - 16){hd_ff[15]}}, hd_ff};
   assign dx_new = {wp_data[63], wp_data[63:32]} - {px_ff[31], px_ff};
   assign dy_new = {wp_data[31], wp_data[31:0]} - {py_ff[31], py_ff};

   // Final rounding, direction sign and clip
   assign zsum   = {cz_ff[ZW-1], cz_ff} + 37'sd65536;
   assign st20   = zsum[36:17];
   assign st_dir = back ? -st20 : st20;
   assign lim20  = $signed({6'd0, cfg.steer_limit});
   always_comb begin
      if (st_dir > lim20) begin
         clip = lim20;
      end else if (st_dir < -lim20) begin
         clip = -lim20;
      end else begin
         clip = st_dir;
      end
   end
   assign neg20 = -clip;

   // Operation decode
   always_comb begin
      px_in    = px_ff;
      py_in    = py_ff;
      hd_in    = hd_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      vzero_in = vzero_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      far_in   = far_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      steer_in = steer_ff;
      case (cmd.op)
         pps_pkg::OP_LATCH: begin
            px_in = req_pos_x;
            py_in = req_pos_y;
            hd_in = req_heading;
         end
         pps_pkg::OP_ZERO: begin
            steer_in = '0;
         end
         pps_pkg::OP_LOAD: begin
            dx_in = dx_new;
            dy_in = dy_new;
            cx_in = {{(CW - 33){dx_new[32]}}, dx_new};
            cy_in = {{(CW - 33){dy_new[32]}}, dy_new};
            cz_in = -(hd_ext <<< 17);
         end
         pps_pkg::OP_QTURN: begin
            if (cz_ff > pps_pkg::HALF_PI) begin
               cx_in = -cy_ff;
               cy_in = cx_ff;
               cz_in = cz_ff - pps_pkg::HALF_PI;
            end else if (cz_ff < -pps_pkg::HALF_PI) begin
               cx_in = cy_ff;
               cy_in = -cx_ff;
               cz_in = cz_ff + pps_pkg::HALF_PI;
            end
         end
         pps_pkg::OP_ROT: begin
            if (!cz_ff[ZW-1]) begin
               cx_in = cx_ff - cy_sh;
               cy_in = cy_ff + cx_sh;
               cz_in = cz_ff - atan_v;
            end else begin
               cx_in = cx_ff + cy_sh;
               cy_in = cy_ff - cx_sh;
               cz_in = cz_ff + atan_v;
            end
         end
         pps_pkg::OP_SQX: begin
            far_in  = far_now;
            prod_in = $signed(mul_p[63:0]);
         end
         pps_pkg::OP_SQY: begin
            acc_in  = $unsigned(prod_ff);
            prod_in = $signed(mul_p[63:0]);
         end
         pps_pkg::OP_SQL: begin
            acc_in  = acc_ff + $unsigned(prod_ff);
            prod_in = $signed(mul_p[63:0]);
         end
         pps_pkg::OP_VINIT: begin
            vzero_in = (cx_ff == '0) && (cy_ff == '0);
            cz_in    = '0;
            if (cx_ff[CW-1]) begin
               if (!cy_ff[CW-1]) begin
                  cx_in = cy_ff;
                  cy_in = -cx_ff;
                  cz_in = pps_pkg::HALF_PI;
               end else begin
                  cx_in = -cy_ff;
                  cy_in = cx_ff;
                  cz_in = -pps_pkg::HALF_PI;
               end
            end
         end
         pps_pkg::OP_VEC: begin
            // atan2 of the zero vector stays zero
            if (!vzero_ff) begin
               if (cy_ff > 50'sd0) begin
                  cx_in = cx_ff + cy_sh;
                  cy_in = cy_ff - cx_sh;
                  cz_in = cz_ff + atan_v;
               end else begin
                  cx_in = cx_ff - cy_sh;
                  cy_in = cy_ff + cx_sh;
                  cz_in = cz_ff - atan_v;
               end
            end
         end
         pps_pkg::OP_RINIT: begin
            cx_in = pps_pkg::INV_GAIN;
            cy_in = '0;
         end
         pps_pkg::OP_MUL1: begin
            prod_in = $signed(mul_p[63:0]);
         end
         pps_pkg::OP_MUL2: begin
            num_in  = prod_ff;
            prod_in = $signed(mul_p[63:0]);
         end
         pps_pkg::OP_MUL3: begin
            cx_in = den_shift[CW-1:0];
            cy_in = num_shift[CW-1:0];
         end
         pps_pkg::OP_FINAL: begin
            steer_in = neg20[14:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      hd_ff    <= hd_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      vzero_ff <= vzero_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      far_ff   <= far_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      steer_ff <= steer_in;
   end

   // Waypoint qualification
   assign status.side_ok = (cfg.drive_direction == pps_pkg::DIR_FORWARD) ?
                           (cx_ff > 50'sd0) : (cx_ff < 50'sd0);
   assign status.dist_ok = far_ff || (acc_ff > $unsigned(prod_ff));

   assign steer_angle = steer_ff;

endmodule

// ===== rtl/pps_ctrl.sv =====
`include "assert_macros.svh"

module pps_ctrl #(
   parameter int unsigned MAX_WAYPOINTS = pps_pkg::MAX_WAYPOINTS_DEF,
   parameter int unsigned CORDIC_STEPS  = pps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pps_pkg::ACTION_W-1:0]       req_action,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pps_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pps_pkg::TARGET_W-1:0]       rsp_target_index,
   input  logic [pps_pkg::DIR_W-1:0]          drive_direction,
   input  pps_pkg::dp_status_type             dp_status,
   output pps_pkg::dp_cmd_type                cmd,
   output logic                               ram_we,
   output logic [$clog2(MAX_WAYPOINTS)-1:0]   ram_waddr,
   output logic                               ram_re,
   output logic [$clog2(MAX_WAYPOINTS)-1:0]   ram_raddr
);

   localparam int unsigned AW = $clog2(MAX_WAYPOINTS);
   localparam int unsigned LW = AW + 1;
   localparam int unsigned SW = $clog2(CORDIC_STEPS);

   typedef enum logic [4:0] {
      S_IDLE,
      S_RD,
      S_LOAD,
      S_SCAN_QT,
      S_SCAN_IT,
      S_SQX,
      S_SQY,
      S_SQL,
      S_CHECK,
      S_V1_INIT,
      S_V1_IT,
      S_RINIT,
      S_ETA_QT,
      S_ETA_IT,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_V2_INIT,
      S_V2_IT,
      S_FINAL,
      S_MISS
   } state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [LW-1:0]               len_ff, len_in;
   logic [SW-1:0]               cnt_ff, cnt_in;
   logic [1:0]                  qt_ff, qt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pps_pkg::STATUS_W-1:0] status_ff, status_in;

   logic          out_free, accept, last_step, more, full;
   logic [LW-1:0] idx_next, len_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign last_step = (cnt_ff == SW'(CORDIC_STEPS - 1));
   assign idx_next  = {1'b0, idx_ff} + LW'(1);
   assign more      = (idx_next < len_ff);
   assign full      = (len_ff >= LW'(MAX_WAYPOINTS));
   assign len_last  = len_ff - LW'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      qt_in        = qt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      cmd.op       = pps_pkg::OP_NONE;
      cmd.step     = pps_pkg::STEP_W'(cnt_ff);
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  pps_pkg::ACT_CLEAR: begin
                     cmd.op       = pps_pkg::OP_ZERO;
                     len_in       = '0;
                     idx_in       = '0;
                     rsp_valid_in = 1'b1;
                     status_in    = pps_pkg::STAT_CLEARED;
                  end
                  pps_pkg::ACT_APPEND: begin
                     cmd.op       = pps_pkg::OP_ZERO;
                     rsp_valid_in = 1'b1;
                     if (!full) begin
                        ram_we    = 1'b1;
                        len_in    = len_ff + LW'(1);
                        status_in = pps_pkg::STAT_STORED;
                     end else begin
                        status_in = pps_pkg::STAT_DROPPED;
                     end
                  end
                  default: begin
                     cmd.op = pps_pkg::OP_LATCH;
                     if (len_ff == '0 || drive_direction > pps_pkg::DIR_REVERSE) begin
                        state_in = S_MISS;
                     end else begin
                        state_in = S_RD;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op   = pps_pkg::OP_LOAD;
            qt_in    = '0;
            state_in = S_SCAN_QT;
         end
         S_SCAN_QT: begin
            cmd.op = pps_pkg::OP_QTURN;
            qt_in  = qt_ff + 2'd1;
            if (qt_ff == 2'd3) begin
               cnt_in   = '0;
               state_in = S_SCAN_IT;
            end
         end
         S_SCAN_IT: begin
            cmd.op = pps_pkg::OP_ROT;
            cnt_in = cnt_ff + SW'(1);
            if (last_step) begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op   = pps_pkg::OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = pps_pkg::OP_SQY;
            state_in = S_SQL;
         end
         S_SQL: begin
            cmd.op   = pps_pkg::OP_SQL;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (dp_status.side_ok && dp_status.dist_ok) begin
               state_in = S_V1_INIT;
            end else if (more) begin
               idx_in   = idx_next[AW-1:0];
               state_in = S_RD;
            end else begin
               state_in = S_MISS;
            end
         end
         S_V1_INIT: begin
            cmd.op   = pps_pkg::OP_VINIT;
            cnt_in   = '0;
            state_in = S_V1_IT;
         end
         S_V1_IT: begin
            cmd.op = pps_pkg::OP_VEC;
            cnt_in = cnt_ff + SW'(1);
            if (last_step) begin
               state_in = S_RINIT;
            end
         end
         S_RINIT: begin
            cmd.op   = pps_pkg::OP_RINIT;
            qt_in    = '0;
            state_in = S_ETA_QT;
         end
         S_ETA_QT: begin
            cmd.op = pps_pkg::OP_QTURN;
            qt_in  = qt_ff + 2'd1;
            if (qt_ff == 2'd3) begin
               cnt_in   = '0;
               state_in = S_ETA_IT;
            end
         end
         S_ETA_IT: begin
            cmd.op = pps_pkg::OP_ROT;
            cnt_in = cnt_ff + SW'(1);
            if (last_step) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.op   = pps_pkg::OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = pps_pkg::OP_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.op   = pps_pkg::OP_MUL3;
            state_in = S_V2_INIT;
         end
         S_V2_INIT: begin
            cmd.op   = pps_pkg::OP_VINIT;
            cnt_in   = '0;
            state_in = S_V2_IT;
         end
         S_V2_IT: begin
            cmd.op = pps_pkg::OP_VEC;
            cnt_in = cnt_ff + SW'(1);
            if (last_step) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               cmd.op       = pps_pkg::OP_FINAL;
               rsp_valid_in = 1'b1;
               status_in    = pps_pkg::STAT_STEERED;
               state_in     = S_IDLE;
            end
         end
         S_MISS: begin
            // No waypoint: park on the last entry, or zero for an empty path
            if (out_free) begin
               cmd.op       = pps_pkg::OP_ZERO;
               rsp_valid_in = 1'b1;
               status_in    = pps_pkg::STAT_NO_WP;
               idx_in       = (len_ff == '0) ? '0 : len_last[AW-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         qt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         qt_ff        <= qt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
   end

   assign ram_waddr        = len_ff[AW-1:0];
   assign ram_raddr        = idx_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_target_index = pps_pkg::TARGET_W'(idx_ff);

   `PPS_ASSERT(a_len_bound, (len_ff <= LW'(MAX_WAYPOINTS)), "path length beyond capacity")
   `PPS_ASSERT_IMPL(a_idx_in_path, (state_ff == S_IDLE && len_ff != '0), ({1'b0, idx_ff} < len_ff), "search index beyond path end")
   `PPS_ASSERT_NEXT(a_found_keeps_idx, (state_ff == S_CHECK && dp_status.side_ok && dp_status.dist_ok), (idx_ff == $past(idx_ff)), "index moved on a hit")
   `PPS_ASSERT_IMPL(a_busy_no_beat, (state_ff != S_IDLE && state_ff != S_FINAL && state_ff != S_MISS), (!rsp_valid_ff), "result beat pending during a scan")

endmodule

// ===== rtl/pure_pursuit_steering_top.sv =====
// Pure-pursuit steering with an anchor point. Clear and append items are
// answered from a registered result without a waypoint scan. A pose step
// examines waypoints from the current search index onward. Per waypoint it
// does a RAM read, a load, four quarter-turn steps, N micro-rotations (N =
// CORDIC_STEPS), the squares of x, y and look-ahead for the distance test and
// one decision; on a hit it vectors, rotates and multiplies for the steering
// angle, on the one shared CORDIC unit (one micro-rotation per cycle) and the
// one shared 33x33 multiplier. The waypoint store needs no clearing after reset.
// Configuration must be written only while the block is idle; it is not enforced.
module pure_pursuit_steering_top #(
   parameter int unsigned MAX_WAYPOINTS = pps_pkg::MAX_WAYPOINTS_DEF,
   parameter int unsigned CORDIC_STEPS  = pps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pps_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [pps_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [pps_pkg::POS_W-1:0]     req_pos_y,
   input  logic signed [pps_pkg::HEAD_W-1:0]    req_heading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pps_pkg::STEER_W-1:0]   rsp_steer_angle,
   output logic [pps_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pps_pkg::TARGET_W-1:0]         rsp_target_index,
   input  logic                                 csr_write_en,
   input  logic [pps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int unsigned AW = $clog2(MAX_WAYPOINTS);

   pps_pkg::cfg_type       cfg_ff;
   pps_pkg::dp_cmd_type    cmd;
   pps_pkg::dp_status_type dp_status;
   logic                   ram_we, ram_re;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [pps_pkg::WP_W-1:0] ram_rdata;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_base      <= 31'd163840;
         cfg_ff.look_fwd        <= 31'd327680;
         cfg_ff.anchor_fwd      <= '0;
         cfg_ff.look_rev        <= 31'd327680;
         cfg_ff.anchor_rev      <= '0;
         cfg_ff.steer_limit     <= 14'd5734;
         cfg_ff.drive_direction <= pps_pkg::DIR_FORWARD;
      end else if (csr_write_en) begin
         case (csr_index)
            pps_pkg::CSR_WHEEL_BASE:  cfg_ff.wheel_base  <= csr_data;
            pps_pkg::CSR_LOOK_FWD:    cfg_ff.look_fwd    <= csr_data;
            pps_pkg::CSR_ANCHOR_FWD:  cfg_ff.anchor_fwd  <= csr_data;
            pps_pkg::CSR_LOOK_REV:    cfg_ff.look_rev    <= csr_data;
            pps_pkg::CSR_ANCHOR_REV:  cfg_ff.anchor_rev  <= csr_data;
            pps_pkg::CSR_STEER_LIMIT: cfg_ff.steer_limit <= csr_data[pps_pkg::LIMIT_W-1:0];
            pps_pkg::CSR_DRIVE_DIR:   cfg_ff.drive_direction <= csr_data[pps_pkg::DIR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pps_ram #(
      .WIDTH (pps_pkg::WP_W),
      .DEPTH (MAX_WAYPOINTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_pos_x, req_pos_y}),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pps_datapath u_dp (
      .clock       (clock),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_heading (req_heading),
      .wp_data     (ram_rdata),
      .status      (dp_status),
      .steer_angle (rsp_steer_angle)
   );

   pps_ctrl #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS),
      .CORDIC_STEPS  (CORDIC_STEPS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_target_index (rsp_target_index),
      .drive_direction  (cfg_ff.drive_direction),
      .dp_status        (dp_status),
      .cmd              (cmd),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_re           (ram_re),
      .ram_raddr        (ram_raddr)
   );

endmodule
